// ----- rtl/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 converter: counter
// width, stream field widths, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Width of the internal byte and unit counters.
  localparam int COUNT_WIDTH = 32;

  // Width of the reported counts in the status word.
  localparam int REPORT_WIDTH = 32;

  // Output tdata: code_unit, bad_sequence, bytes_consumed, units_emitted,
  // padded with zeros to whole bytes.
  localparam int OUT_FIELDS_W = 16 + 1 + REPORT_WIDTH + REPORT_WIDTH;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Decode form thresholds and masks.
  localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
  localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
  localparam logic [7:0]  LEAD2_MIN   = 8'hC0;
  localparam logic [7:0]  CONT_MIN    = 8'h80;
  localparam logic [25:0] SUPP_OFFSET = 26'h0010000;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT0,
    ST_EMIT1,
    ST_STATUS
  } ctrl_state_t;

  // Which word the output register loads.
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_UNIT0,
    EMIT_UNIT1,
    EMIT_STATUS
  } emit_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      accept;  // take the input word
    logic      decode;  // commit one decode step of the window
    emit_sel_t emit;    // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] count;     // bytes in the window
    logic       stopped;   // an invalid byte halted decoding
    logic       end_flag;  // the current string has ended
    logic       dec_ok;    // the front of the window decodes
    logic       two_units; // the last decode gave a surrogate pair
    logic       out_free;  // the output register can take a word
  } dp_status_t;

endpackage

// ----- rtl/utf8_to_utf16_converter.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_converter
// Streaming UTF-8 to UTF-16 converter, one input byte per word, with a
// controller state machine and a separate datapath.
// The first code unit of a full window goes through ST_CHECK, ST_EMIT0 and
// the output register after accept; a stalled receiver holds ST_EMIT0. A
// new input word is taken only in ST_IDLE, after the decode steps and code
// units of the last word are done; the end of a string also flushes the
// forms left in the window and then sends the status word.
// Reset: synchronous rst clears the window count, counters and flags.
// ----------------------------------------------------------------------------
module utf8_to_utf16_converter
  import u8u16_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,  // [7:0] data_byte
  input  logic                  s_tuser,  // [0] has_byte
  input  logic                  s_tlast,  // end_of_string
  // Output stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // [15:0] code_unit, [16] bad_sequence,
                                          // [48:17] bytes_consumed,
                                          // [80:49] units_emitted, rest zero
  output logic                  m_tuser,  // [0] is_status
  output logic                  m_tlast   // last_result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller.
  u8u16_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  u8u16_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ----- rtl/u8u16_ctrl.sv -----
// ----------------------------------------------------------------------------
// u8u16_ctrl
// Controller state machine: accepts one input word, runs decode steps on the
// window, sequences the code units into the output register and closes a
// string with the status word.
// ----------------------------------------------------------------------------
module u8u16_ctrl
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        want_decode;

  // Unless decoding has stopped, a decode is due on a full window, or on any bytes left at the end.
  assign want_decode = !status.stopped &&
                       ((status.count == 3'd4) ||
                        (status.end_flag && (status.count != 3'd0)));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (want_decode) begin
          state_next = status.dec_ok ? ST_EMIT0 : ST_CHECK;
        end else if (status.end_flag) begin
          state_next = ST_STATUS;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT0: begin
        if (status.out_free) state_next = status.two_units ? ST_EMIT1 : ST_CHECK;
      end
      ST_EMIT1: begin
        if (status.out_free) state_next = ST_CHECK;
      end
      ST_STATUS: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_tready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.decode = 1'b0;
    cmd.emit   = EMIT_NONE;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_CHECK: begin
        cmd.decode = want_decode;
      end
      ST_EMIT0: begin
        if (status.out_free) cmd.emit = EMIT_UNIT0;
      end
      ST_EMIT1: begin
        if (status.out_free) cmd.emit = EMIT_UNIT1;
      end
      ST_STATUS: begin
        if (status.out_free) cmd.emit = EMIT_STATUS;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/u8u16_dp.sv -----
// ----------------------------------------------------------------------------
// u8u16_dp
// Datapath: the four-byte window, the form decoder, the saturating byte and
// unit counters and the output register.
// ----------------------------------------------------------------------------
module u8u16_dp
  import u8u16_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  logic [7:0]             win [4];
  logic [2:0]             count;
  logic                   stopped;
  logic                   end_flag;
  logic [COUNT_WIDTH-1:0] byte_cnt;
  logic [COUNT_WIDTH-1:0] unit_cnt;
  logic [15:0]            unit0;
  logic [15:0]            unit1;
  logic                   two_units;

  logic [15:0]            cu_data;
  logic                   bad_data;
  logic [REPORT_WIDTH-1:0] bc_data;
  logic [REPORT_WIDTH-1:0] uc_data;

  // Decoder outputs.
  logic [2:0]  used;
  logic        dec_pair;
  logic [15:0] dec_u0;
  logic [15:0] dec_u1;
  logic [20:0] scalar4;
  logic [25:0] offset4;
  logic        c1_cont;
  logic        c2_cont;
  logic        c3_cont;

  logic [COUNT_WIDTH:0] byte_sum;
  logic [COUNT_WIDTH:0] unit_sum;
  logic                 out_free;

  // Clamp a counter to the width of the status field.
  function automatic logic [REPORT_WIDTH-1:0] report(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'({REPORT_WIDTH{1'b1}})) ? {REPORT_WIDTH{1'b1}} : w[REPORT_WIDTH-1:0];
  endfunction

  // Form decoder on the front of the window, longest form first.
  always_comb begin
    c1_cont  = (win[1] >= CONT_MIN);
    c2_cont  = (win[2] >= CONT_MIN);
    c3_cont  = (win[3] >= CONT_MIN);
    scalar4  = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
    offset4  = 26'(scalar4) - SUPP_OFFSET;
    used     = 3'd0;
    dec_pair = 1'b0;
    dec_u0   = 16'd0;
    dec_u1   = LO_SURR + {6'd0, offset4[9:0]};
    priority if (win[0] >= LEAD4_MIN && count == 3'd4 && c1_cont && c2_cont && c3_cont) begin
      used     = 3'd4;
      dec_pair = 1'b1;
      dec_u0   = HI_SURR + offset4[25:10];
    end else if (win[0] >= LEAD3_MIN && count >= 3'd3 && c1_cont && c2_cont) begin
      used   = 3'd3;
      dec_u0 = {win[0][3:0], win[1][5:0], win[2][5:0]};
    end else if (win[0] >= LEAD2_MIN && count >= 3'd2 && c1_cont) begin
      used   = 3'd2;
      dec_u0 = {5'd0, win[0][4:0], win[1][5:0]};
    end else if (win[0] < CONT_MIN) begin
      used   = 3'd1;
      dec_u0 = {8'd0, win[0]};
    end else begin
      used = 3'd0;
    end
  end

  assign byte_sum = {1'b0, byte_cnt} + (COUNT_WIDTH + 1)'(used);
  assign unit_sum = {1'b0, unit_cnt} + (COUNT_WIDTH + 1)'(dec_pair ? 2'd2 : 2'd1);
  assign out_free = !m_tvalid || m_tready;

  // Window bytes; entries at or above the count are don't-care.
  always_ff @(posedge clk) begin
    if (cmd.accept && s_tuser && !stopped) begin
      win[count[1:0]] <= s_tdata;
    end else if (cmd.decode && used != 3'd0) begin
      unique case (used)
        3'd1: begin
          win[0] <= win[1];
          win[1] <= win[2];
          win[2] <= win[3];
        end
        3'd2: begin
          win[0] <= win[2];
          win[1] <= win[3];
        end
        3'd3: win[0] <= win[3];
        default: ;
      endcase
    end
  end

  // Window count, stop flag, end flag and counters.
  always_ff @(posedge clk) begin
    if (rst || cmd.emit == EMIT_STATUS) begin
      count    <= 3'd0;
      stopped  <= 1'b0;
      end_flag <= 1'b0;
      byte_cnt <= '0;
      unit_cnt <= '0;
    end else if (cmd.accept) begin
      end_flag <= s_tlast;
      if (s_tuser && !stopped) count <= count + 3'd1;
    end else if (cmd.decode) begin
      if (used == 3'd0) begin
        stopped <= 1'b1;
      end else begin
        count    <= count - used;
        byte_cnt <= byte_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : byte_sum[COUNT_WIDTH-1:0];
        unit_cnt <= unit_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : unit_sum[COUNT_WIDTH-1:0];
      end
    end
  end

  // Units waiting to be sent.
  always_ff @(posedge clk) begin
    if (cmd.decode && used != 3'd0) begin
      unit0     <= dec_u0;
      unit1     <= dec_u1;
      two_units <= dec_pair;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      EMIT_UNIT0: begin
        cu_data  <= unit0;
        bad_data <= 1'b0;
        bc_data  <= '0;
        uc_data  <= '0;
        m_tuser  <= 1'b0;
        m_tlast  <= 1'b0;
      end
      EMIT_UNIT1: begin
        cu_data  <= unit1;
        bad_data <= 1'b0;
        bc_data  <= '0;
        uc_data  <= '0;
        m_tuser  <= 1'b0;
        m_tlast  <= 1'b0;
      end
      EMIT_STATUS: begin
        cu_data  <= 16'd0;
        bad_data <= stopped;
        bc_data  <= report(byte_cnt);
        uc_data  <= report(unit_cnt);
        m_tuser  <= 1'b1;
        m_tlast  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign m_tdata = OUT_DATA_W'({uc_data, bc_data, bad_data, cu_data});

  assign status.count     = count;
  assign status.stopped   = stopped;
  assign status.end_flag  = end_flag;
  assign status.dec_ok    = (used != 3'd0);
  assign status.two_units = two_units;
  assign status.out_free  = out_free;

endmodule

// ----- sim/utf16_stream_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_stream_checker
// Watches both streams of the UTF-8 to UTF-16 converter. Every accepted input
// word is run through a transcoder model of its own, and the code units and
// status words that it predicts are queued. Each accepted output word is
// compared field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module utf16_stream_checker
  import u8u16_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tuser,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  input  logic                  m_tlast,
  output logic [31:0]           mismatches,
  output logic [31:0]           outstanding
);

  // Counters saturate at the top of COUNT_WIDTH bits, as in the converter.
  localparam logic [63:0] CNT_MAX = {64{1'b1}} >> (64 - COUNT_WIDTH);
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [15:0] unit;
    logic        status;
    logic        bad;
    logic [31:0] nbytes;
    logic [31:0] nunits;
    logic        last;
  } utf16_word_t;

  utf16_word_t expected_q[$];

  // Model state: the pending window of up to four bytes.
  logic [7:0]  window[4];
  int          window_cnt = 0;
  logic        halted = 1'b0;
  logic [63:0] nbytes = '0;
  logic [63:0] nunits = '0;
  int          errors = 0;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    if (a >= CNT_MAX || b > CNT_MAX - a) return CNT_MAX;
    return a + b;
  endfunction

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic clear_state();
    window_cnt = 0;
    halted     = 1'b0;
    nbytes     = '0;
    nunits     = '0;
  endtask

  task automatic push_unit(input logic [15:0] u);
    utf16_word_t w;
    w      = '0;
    w.unit = u;
    expected_q.push_back(w);
    nunits = sat_add(nunits, 64'd1);
  endtask

  // Decode one form at the front of the window, longest form first.
  task automatic decode_front();
    logic [31:0] c0, c1, c2, c3, cp, hi;
    int used;
    c0   = window[0];
    c1   = window_cnt > 1 ? window[1] : 32'd0;
    c2   = window_cnt > 2 ? window[2] : 32'd0;
    c3   = window_cnt > 3 ? window[3] : 32'd0;
    used = 0;
    if (c0 >= LEAD4_MIN && window_cnt >= 4 && c1 >= CONT_MIN && c2 >= CONT_MIN &&
        c3 >= CONT_MIN) begin
      // Surrogate pair; the code point wraps when it lies below the offset.
      cp = (((c0 & 32'h7) << 18) + ((c1 & 32'h3F) << 12) + ((c2 & 32'h3F) << 6) +
            (c3 & 32'h3F)) & 32'h1F_FFFF;
      cp = cp - 32'h1_0000;
      hi = HI_SURR + (cp >> 10);
      push_unit(hi[15:0]);
      push_unit(LO_SURR + {6'd0, cp[9:0]});
      used = 4;
    end else if (c0 >= LEAD3_MIN && window_cnt >= 3 && c1 >= CONT_MIN &&
                 c2 >= CONT_MIN) begin
      push_unit({c0[3:0], c1[5:0], c2[5:0]});
      used = 3;
    end else if (c0 >= LEAD2_MIN && window_cnt >= 2 && c1 >= CONT_MIN) begin
      push_unit({5'd0, c0[4:0], c1[5:0]});
      used = 2;
    end else if (c0 < CONT_MIN) begin
      push_unit(c0[15:0]);
      used = 1;
    end

    if (used == 0) begin
      halted = 1'b1;
    end else begin
      nbytes = sat_add(nbytes, 64'(used));
      for (int i = 0; i + used < window_cnt; i++) window[i] = window[i + used];
      window_cnt -= used;
    end
  endtask

  // Predict the words that one accepted input word causes.
  task automatic transcode_word(input logic [7:0] data, input logic has, input logic eos);
    utf16_word_t w;
    if (has && !halted) begin
      window[window_cnt] = data;
      window_cnt++;
    end
    // An open string decodes only once the window is full.
    if (!halted && window_cnt == 4) decode_front();
    if (eos) begin
      while (!halted && window_cnt > 0) decode_front();
      w        = '0;
      w.status = 1'b1;
      w.bad    = halted;
      w.nbytes = clip32(nbytes);
      w.nunits = clip32(nunits);
      w.last   = 1'b1;
      expected_q.push_back(w);
      clear_state();
    end else if (halted) begin
      window_cnt = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
    end
  endtask

  task automatic compare_word();
    utf16_word_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: word with nothing expected, got tdata %h tuser %b tlast %b",
                 $time, m_tdata, m_tuser, m_tlast);
    end else begin
      want = expected_q.pop_front();
      check_field("code_unit", {16'd0, want.unit}, {16'd0, m_tdata[15:0]});
      check_field("is_status", {31'd0, want.status}, {31'd0, m_tuser});
      check_field("bad_sequence", {31'd0, want.bad}, {31'd0, m_tdata[16]});
      check_field("bytes_consumed", want.nbytes, m_tdata[48:17]);
      check_field("units_emitted", want.nunits, m_tdata[80:49]);
      check_field("last_result", {31'd0, want.last}, {31'd0, m_tlast});
      check_field("tdata padding", 32'd0, 32'(m_tdata[OUT_DATA_W-1:81]));
    end
  endtask

  // Outputs are compared before the same edge's input is predicted, so a
  // premature word cannot be matched against its own prediction.
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) compare_word();
      if (s_tvalid && s_tready) transcode_word(s_tdata, s_tuser, s_tlast);
    end
    outstanding <= expected_q.size();
    mismatches  <= errors;
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the UTF-8 to UTF-16 converter. Sends a few hand-picked
// strings covering every decode form, an invalid byte, empty words and a
// bare end marker, then random strings built mostly from well-formed
// characters mixed with noise and cut forms. The sender runs in random
// bursts and the receiver stalls in changing patterns; a separate checker
// predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb;
  import u8u16_pkg::*;

  localparam int STRING_ITEMS = 380;
  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 20;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // [7:0] data_byte
  logic                  s_tuser;   // [0] has_byte
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [15:0] code_unit, [16] bad_sequence,
                                    // [48:17] bytes_consumed, [80:49] units_emitted
  logic                  m_tuser;   // [0] is_status
  logic                  m_tlast;
  logic [31:0]           mismatches;
  logic [31:0]           outstanding;

  logic [7:0] str_bytes[$];
  int         items_sent = 0;
  int         burst_left = 0;
  bit         gaps_on = 1'b1;
  int         rx_tick = 0;
  rx_mode_t   rx_mode = RX_OPEN;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  utf8_to_utf16_converter DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  utf16_stream_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver: a tick counter redraws the stall pattern at random.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 97 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= (rx_tick % 4 == 3);
      default:   m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Send one word, opening a new burst with a random gap when the last ends.
  task automatic send_word(input logic [7:0] data, input logic has, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= has;
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (has || eos) items_sent++;
  endtask

  // Send the queued bytes as one string, ending on the last byte or on a
  // separate end marker. Empty words are sprinkled in now and then.
  task automatic send_string(input bit sep_end);
    for (int i = 0; i < str_bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(str_bytes[i], 1'b1, !sep_end && (i == str_bytes.size() - 1));
    end
    if (sep_end || str_bytes.size() == 0)
      send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    str_bytes.delete();
  endtask

  // Queue a lead byte for a form of the given length and some continuations.
  task automatic push_form(input int len, input int conts);
    logic [7:0] lead;
    case (len)
      1:       lead = 8'($urandom_range(0, 8'h7F));
      2:       lead = LEAD2_MIN + 8'($urandom_range(0, 31));
      3:       lead = LEAD3_MIN + 8'($urandom_range(0, 15));
      default: lead = LEAD4_MIN + 8'($urandom_range(0, 15));
    endcase
    str_bytes.push_back(lead);
    repeat (conts) str_bytes.push_back(CONT_MIN | 8'($urandom_range(0, 8'h3F)));
  endtask

  initial begin
    int nchars;
    int pick;
    int len;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'd0;
    s_tuser  <= 1'b0;
    s_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Single-byte extremes, ending on the last byte.
    str_bytes = '{8'h00, 8'h7F};
    send_string(1'b0);
    // Two-byte extremes, closed by a separate end marker.
    str_bytes = '{8'hC2, 8'h80, 8'hDF, 8'hBF};
    send_string(1'b1);
    // Three-byte extremes.
    str_bytes = '{8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF};
    send_string(1'b0);
    // Surrogate pairs, the second with the largest lead byte and code point.
    str_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'hFF, 8'hBF, 8'hBF, 8'hBF};
    send_string(1'b0);
    // Invalid leading byte, an empty word, a later byte, then a bare end.
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b0);
    send_word(8'h41, 1'b1, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);

    // Random strings: mostly well-formed characters, some noise and cut forms.
    while (items_sent < STRING_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      nchars  = $urandom_range(0, 10);
      repeat (nchars) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          len = $urandom_range(1, 4);
          push_form(len, len - 1);
        end else if (pick < 90) begin
          str_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          len = $urandom_range(2, 4);
          push_form(len, $urandom_range(0, len - 2));
        end
      end
      send_string($urandom_range(0, 9) < 3);
    end
    s_tvalid <= 1'b0;

    // Wait for every expected word, then let the block settle.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog against a hung stream.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/u8u16_pkg.sv
rtl/u8u16_ctrl.sv
rtl/u8u16_dp.sv
rtl/utf8_to_utf16_converter.sv
sim/utf16_stream_checker.sv
sim/tb.sv
